>>> rtl/etrp_pkg.sv
// package for the eeprom tlv record parser
// kinds, phases, sizes and the word types shared by front and back parts
package etrp_pkg;

  localparam int unsigned ImageBytes    = 256;
  localparam int unsigned OffW          = $clog2(ImageBytes);
  localparam int unsigned AssemblyChars = 12;
  localparam int unsigned ProductChars  = 12;
  localparam int unsigned DateChars     = 10;
  localparam int unsigned SerialChars   = 11;
  localparam int unsigned MacChars      = 12;
  localparam int unsigned QDepth        = 4;
  localparam int unsigned QAw           = $clog2(QDepth);

  typedef enum logic [3:0] {
    KIND_PCA      = 4'd0,
    KIND_SERIAL   = 4'd1,
    KIND_DATE     = 4'd2,
    KIND_ASSEMBLY = 4'd3,
    KIND_PRODUCT  = 4'd4,
    KIND_MAC      = 4'd5,
    KIND_MAJOR    = 4'd6,
    KIND_MINOR    = 4'd7,
    KIND_DONE     = 4'd8,
    KIND_HEADER   = 4'd9,
    KIND_FORMAT   = 4'd10,
    KIND_HEXERR   = 4'd11
  } kind_e;

  typedef enum logic [3:0] {
    PH_HEADER, PH_SIZE, PH_FORMAT, PH_PCA, PH_SERIAL,
    PH_KVN, PH_TYPE, PH_LEN, PH_BODY, PH_HALT
  } phase_e;

  localparam logic [7:0] RecEnd      = 8'h00;
  localparam logic [7:0] RecDate     = 8'h02;
  localparam logic [7:0] RecProduct  = 8'h03;
  localparam logic [7:0] RecAssembly = 8'h04;
  localparam logic [7:0] RecMac      = 8'h05;
  localparam logic [7:0] RecVersion  = 8'h0B;
  localparam logic [7:0] RecSerial   = 8'h0E;

  localparam logic [0:0] RegHeader = 1'b0;
  localparam logic [0:0] RegFormat = 1'b1;

  // one result word
  typedef struct packed {
    kind_e      kind;
    logic [7:0] position;
    logic [7:0] value;
  } res_t;

  // all results of one byte, up to three
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
    res_t       r2;
  } bundle_t;

  // hex digit value, invalid flag in bit 4
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] d;
    d = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) d = {1'b0, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      d = {1'b0, c[3:0] + 4'd9};
    return d;
  endfunction

endpackage

>>> rtl/etrp_front.sv
// front part: runs the byte parser and bundles the results of each byte
// depends on etrp_pkg
module etrp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  output logic               push_o,
  output etrp_pkg::bundle_t  bundle_o,
  input  logic               q_full_i
);
  import etrp_pkg::*;

  logic [31:0]     hdr_q, fmt_q;
  logic [OffW-1:0] off_q, off_d;
  phase_e          ph_q, ph_d;
  logic [15:0]     acc_q, acc_d;
  logic [7:0]      rtype_q, rtype_d;
  logic [15:0]     left_q, left_d;
  logic [7:0]      cur_q, cur_d;
  logic [7:0]      mach_q, mach_d;
  logic [7:0]      maj_q, maj_d;
  logic [7:0]      min_q, min_d;
  logic            dot_q, dot_d;
  logic            fin_q, fin_d;
  bundle_t         b;

  assign in_ready_o = !q_full_i;
  wire take = in_valid_i && in_ready_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q <= 32'h0000_0003;
      fmt_q <= 32'h3030_3032;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegHeader) hdr_q <= cfg_data_i;
      else fmt_q <= cfg_data_i;
    end
  end

  // per-byte parse step
  always_comb begin
    logic [7:0]  c;
    logic [4:0]  hd;
    logic [7:0]  dv;
    logic [7:0]  sel;
    logic [15:0] accn;
    logic        endrec;
    c = data_byte_i;
    hd = hex_digit(c);
    dv = hd[4] ? 8'hFF : {4'd0, hd[3:0]};
    off_d = off_q; ph_d = ph_q; acc_d = acc_q; rtype_d = rtype_q;
    left_d = left_q; cur_d = cur_q; mach_d = mach_q; maj_d = maj_q;
    min_d = min_q; dot_d = dot_q; fin_d = fin_q;
    b = '0;
    sel = 8'd0;
    accn = 16'd0;
    endrec = 1'b0;
    unique case (ph_q)
      PH_HEADER: begin
        unique case (off_q[1:0])
          2'd0: sel = hdr_q[31:24];
          2'd1: sel = hdr_q[23:16];
          2'd2: sel = hdr_q[15:8];
          default: sel = hdr_q[7:0];
        endcase
        if (sel != c) begin
          b.r0 = '{KIND_HEADER, 8'd0, 8'd0}; b.cnt = 2'd1;
          fin_d = 1'b1; ph_d = PH_HALT;
        end else if (off_q >= OffW'(3)) ph_d = PH_SIZE;
      end
      PH_SIZE: if (off_q >= OffW'(7)) ph_d = PH_FORMAT;
      PH_FORMAT: begin
        unique case (off_q[1:0])
          2'd0: sel = fmt_q[31:24];
          2'd1: sel = fmt_q[23:16];
          2'd2: sel = fmt_q[15:8];
          default: sel = fmt_q[7:0];
        endcase
        if (sel != c) begin
          b.r0 = '{KIND_FORMAT, 8'd0, 8'd0}; b.cnt = 2'd1;
          fin_d = 1'b1; ph_d = PH_HALT;
        end else if (off_q >= OffW'(11)) ph_d = PH_PCA;
      end
      PH_PCA: begin
        b.r0 = '{KIND_PCA, 8'(off_q - OffW'(12)), c}; b.cnt = 2'd1;
        if (off_q >= OffW'(23)) ph_d = PH_SERIAL;
      end
      PH_SERIAL: begin
        b.r0 = '{KIND_SERIAL, 8'(off_q - OffW'(24)), c}; b.cnt = 2'd1;
        if (off_q >= OffW'(34)) ph_d = PH_KVN;
      end
      PH_KVN: if (off_q >= OffW'(37)) begin
        ph_d = PH_TYPE; cur_d = 8'd0; acc_d = 16'd0;
      end
      PH_TYPE, PH_LEN: begin
        if (hd[4]) begin
          b.r0 = '{KIND_HEXERR, 8'd0, 8'd0}; b.cnt = 2'd1;
          fin_d = 1'b1; ph_d = PH_HALT;
        end else begin
          accn = {acc_q[11:0], hd[3:0]};
          acc_d = accn;
          cur_d = cur_q + 8'd1;
          if (ph_q == PH_TYPE) begin
            if (cur_q >= 8'd1) begin
              rtype_d = accn[7:0]; acc_d = 16'd0; cur_d = 8'd0; ph_d = PH_LEN;
            end
          end else if (cur_q >= 8'd3) begin
            left_d = accn; acc_d = 16'd0; cur_d = 8'd0;
            maj_d = 8'd0; min_d = 8'd0; dot_d = 1'b0; mach_d = 8'd0;
            if (rtype_q == RecEnd) begin
              b.r0 = '{KIND_DONE, 8'd0, 8'd0}; b.cnt = 2'd1;
              fin_d = 1'b1; ph_d = PH_HALT;
            end else if (accn == 16'd0) begin
              dot_d = 1'b0; acc_d = 16'd0;
              endrec = 1'b1;
            end else ph_d = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        unique case (rtype_q)
          RecDate: if (cur_q < 8'(DateChars)) begin
            b.r0 = '{KIND_DATE, cur_q, c}; b.cnt = 2'd1;
          end
          RecAssembly: if (cur_q < 8'(AssemblyChars)) begin
            b.r0 = '{KIND_ASSEMBLY, cur_q, c}; b.cnt = 2'd1;
          end
          RecProduct: if (cur_q < 8'(ProductChars)) begin
            b.r0 = '{KIND_PRODUCT, cur_q, c}; b.cnt = 2'd1;
          end
          RecSerial: if (cur_q < 8'(SerialChars)) begin
            b.r0 = '{KIND_SERIAL, cur_q, c}; b.cnt = 2'd1;
          end
          RecMac: if (cur_q < 8'(MacChars)) begin
            if (!cur_q[0]) mach_d = dv;
            else begin
              b.r0 = '{KIND_MAC, {1'b0, cur_q[7:1]}, {mach_q[3:0], 4'd0} + dv};
              b.cnt = 2'd1;
            end
          end
          RecVersion: begin
            if (c == 8'h2E) begin
              maj_d = acc_q[7:0]; min_d = 8'd0; dot_d = 1'b1;
            end else min_d = 8'(min_q * 8'd10) + dv;
            acc_d = {8'd0, 8'(acc_q[7:0] * 8'd10) + dv};
          end
          default: ;
        endcase
        if (cur_q != 8'hFF) cur_d = cur_q + 8'd1;
        left_d = left_q - 16'd1;
        if (left_q == 16'd1) endrec = 1'b1;
      end
      default: ;
    endcase
    // record end: version results then back to type digits
    if (endrec) begin
      if (rtype_q == RecVersion) begin
        b.r1 = '{KIND_MAJOR, 8'd0, dot_d ? maj_d : acc_d[7:0]};
        b.r2 = '{KIND_MINOR, 8'd0, dot_d ? min_d : 8'd0};
        if (b.cnt == 2'd0) begin
          b.r0 = b.r1; b.r1 = b.r2;
        end
        b.cnt = b.cnt + 2'd2;
      end
      ph_d = PH_TYPE; cur_d = 8'd0; acc_d = 16'd0;
    end
    // image end
    if (last_byte_i || off_q == OffW'(ImageBytes - 1)) begin
      if (!fin_d) begin
        unique case (b.cnt)
          2'd0: b.r0 = '{KIND_DONE, 8'd0, 8'd0};
          2'd1: b.r1 = '{KIND_DONE, 8'd0, 8'd0};
          default: b.r2 = '{KIND_DONE, 8'd0, 8'd0};
        endcase
        b.cnt = b.cnt + 2'd1;
      end
      off_d = '0; ph_d = PH_HEADER; acc_d = '0; rtype_d = '0; left_d = '0;
      cur_d = '0; mach_d = '0; maj_d = '0; min_d = '0; dot_d = 1'b0; fin_d = 1'b0;
    end else off_d = off_q + OffW'(1);
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '0; ph_q <= PH_HEADER; acc_q <= '0; rtype_q <= '0;
      left_q <= '0; cur_q <= '0; mach_q <= '0; maj_q <= '0;
      min_q <= '0; dot_q <= 1'b0; fin_q <= 1'b0;
    end else if (take) begin
      off_q <= off_d; ph_q <= ph_d; acc_q <= acc_d; rtype_q <= rtype_d;
      left_q <= left_d; cur_q <= cur_d; mach_q <= mach_d; maj_q <= maj_d;
      min_q <= min_d; dot_q <= dot_d; fin_q <= fin_d;
    end
  end

  assign push_o   = take && (b.cnt != 2'd0);
  assign bundle_o = b;
endmodule

>>> rtl/etrp_queue.sv
// short queue of result bundles between front and back parts
// depends on etrp_pkg
module etrp_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  etrp_pkg::bundle_t  data_i,
  output logic               full_o,
  output logic               empty_o,
  input  logic               pop_i,
  output etrp_pkg::bundle_t  data_o
);
  import etrp_pkg::*;

  bundle_t      mem_q [QDepth];
  logic [QAw-1:0] wp_q, rp_q;
  logic [QAw:0]   cnt_q;

  assign full_o  = cnt_q == (QAw+1)'(QDepth);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rp_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + QAw'(1);
      if (pop_i) rp_q <= rp_q + QAw'(1);
      cnt_q <= cnt_q + (QAw+1)'(push_i) - (QAw+1)'(pop_i);
    end
  end
endmodule

>>> rtl/etrp_back.sv
// back part: serialises each bundle into result words on the output
// depends on etrp_pkg
module etrp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  etrp_pkg::bundle_t  bundle_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [3:0]         kind_o,
  output logic [7:0]         position_o,
  output logic [7:0]         value_o,
  output logic               run_last_o
);
  import etrp_pkg::*;

  logic [1:0] idx_q, idx_d;
  res_t       cur;
  logic       last;

  // pick the word at the current index
  always_comb begin
    unique case (idx_q)
      2'd0: cur = bundle_i.r0;
      2'd1: cur = bundle_i.r1;
      default: cur = bundle_i.r2;
    endcase
    last  = (idx_q + 2'd1) == bundle_i.cnt;
    idx_d = idx_q;
    if (out_valid_o && out_ready_i) idx_d = last ? 2'd0 : idx_q + 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) idx_q <= 2'd0;
    else idx_q <= idx_d;
  end

  assign out_valid_o = !empty_i;
  assign pop_o       = out_valid_o && out_ready_i && last;
  assign kind_o      = cur.kind;
  assign position_o  = cur.position;
  assign value_o     = cur.value;
  assign run_last_o  = last;
endmodule

>>> rtl/eeprom_tlv_record_parser_core.sv
// Board EEPROM TLV record parser, top level
// Input channel in_valid_i/in_ready_o carries one EEPROM word per cycle
// (data_byte_i, last_byte_i) while in_ready_o is high. Output channel
// out_valid_o/out_ready_i carries result words (kind_o, position_o,
// value_o, run_last_o). The front part parses a word in the cycle it is
// taken and pushes all of its results (up to three) into a four-entry
// queue; the back part hands them out one per cycle while out_ready_i is
// high. Results are offered from the queue storage registers.
// Throughput: one input word per cycle while results average at most one
// per word and the receiver is ready. When the receiver stalls, the queue
// fills and in_ready_o drops; nothing is lost. Reset clears the parser
// state and the queue and sets the header and format registers to their
// defaults. Register writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect
// at once; indexes beyond one are ignored.
// Depends on etrp_pkg, etrp_front, etrp_queue, etrp_back.
module eeprom_tlv_record_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  kind_o,
  output logic [7:0]  position_o,
  output logic [7:0]  value_o,
  output logic        run_last_o
);
  import etrp_pkg::*;

  logic    push, full, empty, pop;
  bundle_t wb, rb;

  etrp_front u_front (
    .clk_i, .rst_ni,
    .cfg_we_i   (cfg_we_i && cfg_idx_i[1] == 1'b0),
    .cfg_idx_i  (cfg_idx_i[0]),
    .cfg_data_i,
    .in_valid_i, .in_ready_o, .data_byte_i, .last_byte_i,
    .push_o (push), .bundle_o (wb), .q_full_i (full)
  );

  etrp_queue u_queue (
    .clk_i, .rst_ni,
    .push_i (push), .data_i (wb), .full_o (full), .empty_o (empty),
    .pop_i (pop), .data_o (rb)
  );

  etrp_back u_back (
    .clk_i, .rst_ni,
    .empty_i (empty), .bundle_i (rb), .pop_o (pop),
    .out_valid_o, .out_ready_i, .kind_o, .position_o, .value_o, .run_last_o
  );
endmodule

>>> test/tb.sv
// testbench for the board eeprom tlv record parser core
// drives whole eeprom images, predicts every result word and checks them in order
// depends on etrp_pkg and eeprom_tlv_record_parser_core
`timescale 1ns / 1ps

module tb;
  import etrp_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] position;
    logic [7:0] value;
    logic       run_last;
  } word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = '0;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [3:0]  kind_o;
  logic [7:0]  position_o;
  logic [7:0]  value_o;
  logic        run_last_o;

  eeprom_tlv_record_parser_core dut (.*);

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  byte_t pending_bytes[$];
  word_t expected_words[$];
  int    errors = 0;
  bit    quiet = 1'b0;

  // parser shadow state
  logic [31:0] hdr_reg, fmt_reg;
  int unsigned offset;
  phase_e      ph;
  logic [15:0] accum;
  logic [7:0]  rtype;
  logic [15:0] remaining;
  logic [7:0]  cursor;
  logic [7:0]  mac_hi;
  logic [7:0]  major_acc, minor_acc;
  bit          dot_flag, halted;
  word_t       step_words[$];

  function automatic void put(kind_e k, logic [7:0] p, logic [7:0] v);
    step_words.push_back('{k, p, v, 1'b0});
  endfunction

  function automatic void clear_parser();
    offset = 0; ph = PH_HEADER; accum = 0; rtype = 0; remaining = 0; cursor = 0;
    mac_hi = 0; major_acc = 0; minor_acc = 0; dot_flag = 0; halted = 0;
  endfunction

  function automatic void stop_with(kind_e k);
    put(k, 0, 0);
    halted = 1;
    ph = PH_HALT;
  endfunction

  function automatic int digit_val(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic void close_record();
    if (rtype == RecVersion) begin
      if (dot_flag) begin
        put(KIND_MAJOR, 0, major_acc);
        put(KIND_MINOR, 0, minor_acc);
      end else begin
        put(KIND_MAJOR, 0, accum[7:0]);
        put(KIND_MINOR, 0, 0);
      end
    end
    ph = PH_TYPE; cursor = 0; accum = 0;
  endfunction

  // work out the result words of one accepted byte
  function automatic void parse_byte(byte_t b);
    int         d;
    logic [7:0] dv;
    int unsigned sh;
    step_words.delete();
    case (ph)
      PH_HEADER: begin
        sh = (3 - (offset & 3)) * 8;
        if (hdr_reg[sh +: 8] != b.data) stop_with(KIND_HEADER);
        else if (offset >= 3) ph = PH_SIZE;
      end
      PH_SIZE: if (offset >= 7) ph = PH_FORMAT;
      PH_FORMAT: begin
        sh = (3 - ((offset - 8) & 3)) * 8;
        if (fmt_reg[sh +: 8] != b.data) stop_with(KIND_FORMAT);
        else if (offset >= 11) ph = PH_PCA;
      end
      PH_PCA: begin
        put(KIND_PCA, offset - 12, b.data);
        if (offset >= 23) ph = PH_SERIAL;
      end
      PH_SERIAL: begin
        put(KIND_SERIAL, offset - 24, b.data);
        if (offset >= 34) ph = PH_KVN;
      end
      PH_KVN: if (offset >= 37) begin
        ph = PH_TYPE; cursor = 0; accum = 0;
      end
      PH_TYPE, PH_LEN: begin
        d = digit_val(b.data);
        if (d < 0) stop_with(KIND_HEXERR);
        else begin
          accum = accum * 16 + d;
          cursor++;
          if (ph == PH_TYPE) begin
            if (cursor >= 2) begin
              rtype = accum[7:0]; accum = 0; cursor = 0; ph = PH_LEN;
            end
          end else if (cursor >= 4) begin
            remaining = accum; accum = 0; cursor = 0;
            major_acc = 0; minor_acc = 0; dot_flag = 0; mac_hi = 0;
            if (rtype == RecEnd) stop_with(KIND_DONE);
            else if (remaining == 0) close_record();
            else ph = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        d = digit_val(b.data);
        dv = (d < 0) ? 8'hff : d[7:0];
        case (rtype)
          RecDate:     if (cursor < DateChars) put(KIND_DATE, cursor, b.data);
          RecAssembly: if (cursor < AssemblyChars) put(KIND_ASSEMBLY, cursor, b.data);
          RecProduct:  if (cursor < ProductChars) put(KIND_PRODUCT, cursor, b.data);
          RecSerial:   if (cursor < SerialChars) put(KIND_SERIAL, cursor, b.data);
          RecMac: if (cursor < MacChars) begin
            if (!cursor[0]) mac_hi = dv;
            else put(KIND_MAC, cursor >> 1, mac_hi * 16 + dv);
          end
          RecVersion: begin
            if (b.data == ".") begin
              major_acc = accum[7:0]; minor_acc = 0; dot_flag = 1;
            end else minor_acc = minor_acc * 10 + dv;
            accum = (accum * 10 + dv) & 16'hff;
          end
          default: ;
        endcase
        if (cursor < 255) cursor++;
        remaining--;
        if (remaining == 0) close_record();
      end
      default: ;
    endcase
    if (b.last || offset + 1 >= ImageBytes) begin
      if (!halted) put(KIND_DONE, 0, 0);
      clear_parser();
    end else offset++;
    if (step_words.size() > 0) step_words[$].run_last = 1'b1;
    foreach (step_words[i]) expected_words.push_back(step_words[i]);
  endfunction

  // image building
  function automatic void add(logic [7:0] v, bit lst = 0);
    pending_bytes.push_back('{v, lst});
  endfunction

  function automatic logic [7:0] hex_char(int unsigned n);
    n &= 15;
    if (n < 10) return "0" + n;
    return ($urandom_range(1) ? "a" : "A") + n - 10;
  endfunction

  function automatic void add_hex(int unsigned v, int unsigned n);
    for (int i = n - 1; i >= 0; i--) add(hex_char(v >> (4 * i)));
  endfunction

  function automatic void add_prefix();
    for (int i = 3; i >= 0; i--) add(hdr_reg[8 * i +: 8]);
    for (int i = 0; i < 4; i++) add($urandom);
    for (int i = 3; i >= 0; i--) add(fmt_reg[8 * i +: 8]);
    for (int i = 0; i < 26; i++) add($urandom);
  endfunction

  // record type, length and body, with body content suited to its type
  function automatic void add_record(logic [7:0] t, int unsigned len);
    logic [7:0] c;
    add_hex(t, 2);
    add_hex(len, 4);
    for (int i = 0; i < len; i++) begin
      case (t)
        RecMac: c = ($urandom_range(15) == 0) ? $urandom : hex_char($urandom);
        RecVersion: c = ($urandom_range(3) == 0) ? "." :
                        ($urandom_range(9) == 0) ? $urandom : "0" + $urandom_range(9);
        default: c = $urandom;
      endcase
      add(c);
    end
  endfunction

  // random, mostly well-formed short image
  function automatic void add_image();
    int unsigned start, len, lim;
    logic [7:0]  t;
    logic [7:0]  types[8] = '{RecDate, RecProduct, RecAssembly, RecMac,
                             RecVersion, RecSerial, 8'h07, 8'hf3};
    start = pending_bytes.size();
    lim = $urandom_range(60, 72);
    case ($urandom_range(15))
      0: begin
        add(hdr_reg[31:24] ^ (8'h1 << $urandom_range(7)), 1);
        return;
      end
      1: begin
        for (int i = 3; i >= 0; i--) add(hdr_reg[8 * i +: 8]);
        for (int i = 0; i < 4; i++) add($urandom);
        add(fmt_reg[31:24]);
        add(fmt_reg[23:16] ^ 8'h80);
        add($urandom, 1);
        return;
      end
      default: add_prefix();
    endcase
    while (pending_bytes.size() - start < lim - 20) begin
      t = types[$urandom_range(7)];
      len = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 14);
      add_record(t, len);
      if ($urandom_range(19) == 0) begin
        add(hex_char($urandom)); add("g");
      end
    end
    if (pending_bytes.size() - start >= 256) return;
    case ($urandom_range(3))
      0: add_record(RecEnd, 0);
      1: ;
      default: ;
    endcase
    if (pending_bytes.size() - start < 256 && !pending_bytes[$].last)
      pending_bytes[$].last = 1'b1;
    else if (pending_bytes.size() - start < 256) add($urandom, 1);
  endfunction

  // register write while idle
  task automatic write_reg(logic [1:0] idx, logic [31:0] v);
    @(negedge clk_i);
    cfg_we_i = 1'b1; cfg_idx_i = idx; cfg_data_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == 2'(RegHeader)) hdr_reg = v;
    else if (idx == 2'(RegFormat)) fmt_reg = v;
  endtask

  task automatic drain();
    while (pending_bytes.size() > 0 || expected_words.size() > 0 || in_valid_i)
      @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  // driver: bytes from the pending queue, random gaps
  int gap_in = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        // accepted on the last rising edge
      end
      if (!in_valid_i) begin
        if (gap_in > 0) gap_in--;
        else if (pending_bytes.size() > 0) begin
          {data_byte_i, last_byte_i} <= pending_bytes.pop_front();
          in_valid_i <= 1'b1;
        end
      end
    end
  end

  // input acceptance and prediction at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      parse_byte('{data_byte_i, last_byte_i});
      in_valid_i <= #1 1'b0;
      if (!quiet && $urandom_range(5) == 0) gap_in = $urandom_range(1, 6);
    end
  end

  // monitor: check each result word against the oldest expectation
  int stall_out = 0;
  always @(posedge clk_i) begin
    word_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word kind %0d pos %0d val %0d last %0d",
                 $time, kind_o, position_o, value_o, run_last_o);
        errors++;
      end else begin
        w = expected_words.pop_front();
        if (w.kind != kind_o || w.position != position_o || w.value != value_o ||
            w.run_last != run_last_o) begin
          $display("%0t: expected kind %0d pos %0d val %0d last %0d, got %0d %0d %0d %0d",
                   $time, w.kind, w.position, w.value, w.run_last,
                   kind_o, position_o, value_o, run_last_o);
          errors++;
        end
      end
    end
  end

  // receiver stalls in bursts
  always @(negedge clk_i) begin
    if (!rst_ni) out_ready_i <= 1'b0;
    else if (stall_out > 0) begin
      stall_out--;
      out_ready_i <= 1'b0;
    end else if (!quiet && $urandom_range(7) == 0) begin
      stall_out = $urandom_range(0, 5);
      out_ready_i <= 1'b0;
    end else out_ready_i <= 1'b1;
  end

  // main sequence
  initial begin
    hdr_reg = 32'h0000_0003;
    fmt_reg = 32'h3030_3032;
    clear_parser();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: date, mac and version records, empty version, dots, end record
    add_prefix();
    add_record(RecDate, 3);
    add_record(RecMac, 12);
    add_record(RecVersion, 0);
    add_hex(RecVersion, 2); add_hex(5, 4);
    add("1"); add("."); add("2"); add("."); add("9");
    add_record(RecEnd, 0);
    add(8'hff, 1);
    add(8'h00); add(8'h00); add(8'h00); add(8'hff, 1);
    drain();

    // extreme register values
    write_reg(2'(RegHeader), 32'hffff_ffff);
    write_reg(2'(RegFormat), 32'h0000_0000);
    write_reg(2'd3, 32'h1234_5678);
    add_prefix();
    add_record(RecSerial, 14);
    add_record(RecAssembly, 13);
    add_record(RecProduct, 2);
    add("z");
    add(8'h00, 1);
    drain();

    // random image with fresh register values
    write_reg(2'(RegHeader), $urandom);
    write_reg(2'(RegFormat), $urandom);
    add_image();
    drain();

    // no idling at the end, default registers
    quiet = 1'b1;
    write_reg(2'(RegHeader), 32'h0000_0003);
    write_reg(2'(RegFormat), 32'h3030_3032);
    add_image();
    drain();

    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
